/* src/gtg_pkg.sv */
// Shared types, widths and constants of the go-to-goal speed command block.
// Used by gtg_cordic and go_to_goal_speed_command_top; depends on nothing.
package gtg_pkg;

  // Guard bits added below the Q7.8 position difference before the CORDIC.
  localparam int GUARD = 6;
  // CORDIC vector width: a 17 bit difference, the guard bits and the CORDIC gain.
  localparam int XW = 26;
  // Angle accumulator width, Q.20 radians.
  localparam int ZW = 24;
  // Width of the distance product and of the unsigned Q11.8 distance taken from it.
  localparam int PW = XW - 1 + 16;
  localparam int DW = PW - (16 + GUARD);
  // Width of the raw speed product after the Q4.8 gain shift.
  localparam int SW = DW + 12 - 8;

  localparam logic [15:0] INV_GAIN_Q16 = 16'd39797;
  localparam int HALF_PI_Q20 = 1647099;
  localparam int PI_Q12 = 12868;
  localparam int DIST_MIN_Q8 = 25;
  localparam int ERR_MAX_Q12 = 819;
  localparam int MAX_STAGES = 20;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_GOAL_X = 2'd0;
  localparam logic [1:0] REG_GOAL_Y = 2'd1;
  localparam logic [1:0] REG_SPEED_GAIN = 2'd2;
  localparam logic [1:0] REG_SPEED_LIMIT = 2'd3;

  // One vector in flight through the CORDIC.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } gtg_vec_t;

  // Elementary angles atan(2^-i) in Q.20 radians.
  function automatic logic signed [ZW-1:0] atan_q20(input int idx);
    logic signed [ZW-1:0] val;
    case (idx)
      0: val = 24'sd823550;
      1: val = 24'sd486170;
      2: val = 24'sd256879;
      3: val = 24'sd130396;
      4: val = 24'sd65451;
      5: val = 24'sd32757;
      6: val = 24'sd16383;
      7: val = 24'sd8192;
      8: val = 24'sd4096;
      9: val = 24'sd2048;
      10: val = 24'sd1024;
      11: val = 24'sd512;
      12: val = 24'sd256;
      13: val = 24'sd128;
      14: val = 24'sd64;
      15: val = 24'sd32;
      16: val = 24'sd16;
      17: val = 24'sd8;
      18: val = 24'sd4;
      19: val = 24'sd2;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

/* src/gtg_cordic.sv */
// Pipelined vectoring CORDIC, one micro-rotation per register stage.
// Depends on gtg_pkg for the vector type and the elementary angle table.
module gtg_cordic #(
  parameter int STAGES = 14,
  parameter int TAG_W = 15
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  gtg_pkg::gtg_vec_t    in_vec,
  input  logic [TAG_W-1:0]     in_tag,
  output logic                 out_valid,
  output gtg_pkg::gtg_vec_t    out_vec,
  output logic [TAG_W-1:0]     out_tag
);

  logic [STAGES-1:0]  vld_r;
  gtg_pkg::gtg_vec_t  vec_r [STAGES];
  logic [TAG_W-1:0]   tag_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic              src_vld;
    gtg_pkg::gtg_vec_t src_vec;
    logic [TAG_W-1:0]  src_tag;
    gtg_pkg::gtg_vec_t vec_nxt;

    if (i == 0) begin : g_first
      assign src_vld = in_valid;
      assign src_vec = in_vec;
      assign src_tag = in_tag;
    end else begin : g_next
      assign src_vld = vld_r[i-1];
      assign src_vec = vec_r[i-1];
      assign src_tag = tag_r[i-1];
    end

    // Rotate toward the x axis; the shifts are arithmetic, so they floor.
    always_comb begin
      if (src_vec.y > 0) begin
        vec_nxt.x = src_vec.x + (src_vec.y >>> i);
        vec_nxt.y = src_vec.y - (src_vec.x >>> i);
        vec_nxt.z = src_vec.z + gtg_pkg::atan_q20(i);
      end else begin
        vec_nxt.x = src_vec.x - (src_vec.y >>> i);
        vec_nxt.y = src_vec.y + (src_vec.x >>> i);
        vec_nxt.z = src_vec.z - gtg_pkg::atan_q20(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      vec_r[i] <= vec_nxt;
      tag_r[i] <= src_tag;
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_vec   = vec_r[STAGES-1];
  assign out_tag   = tag_r[STAGES-1];

endmodule

/* src/go_to_goal_speed_command_top.sv */
// Top level of the go-to-goal speed command block: APB register file and pipeline.
// Depends on gtg_pkg and instantiates gtg_cordic.
//
// The block turns a stream of poses into speed commands toward a goal.
// A pose beat (in_pos_x, in_pos_y in Q7.8, in_heading in Q2.12 radians) is
// taken at every rising edge where start is high and busy is low. busy never
// rises, so a new pose can enter on every cycle: the throughput is one beat
// per clock, set by a fully pipelined CORDIC with one micro-rotation per stage.
// Each pose gives exactly one result beat: out_valid is high for one cycle
// with out_forward_speed and out_turn_rate. A pose passes through a register
// that forms and prerotates the goal vector, CORDIC_STAGES rotation stages,
// one stage for the distance multiply and heading error, one for the gain
// multiply and one to select and saturate the command.
// The receiver cannot stall, so results simply flow out in order.
// A synchronous reset (rst_n low) empties the pipeline and loads the goal
// (1.0, 1.0), a gain of 1.0 and a speed limit of 3.0. Registers are written
// over the APB port at 4 * index and should only change while no pose is in
// flight; reads return the current values.
module go_to_goal_speed_command_top #(
  parameter int CORDIC_STAGES = 14
) (
  input  logic               clk,
  input  logic               rst_n,
  // Pose channel.
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [14:0] in_heading,
  // Command channel.
  output logic               out_valid,
  output logic [14:0]        out_forward_speed,
  output logic [14:0]        out_turn_rate,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int XW = gtg_pkg::XW;
  localparam int ZW = gtg_pkg::ZW;
  localparam int PW = gtg_pkg::PW;
  localparam int DW = gtg_pkg::DW;
  localparam int SW = gtg_pkg::SW;

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic signed [15:0] goal_x_r;
  logic signed [15:0] goal_y_r;
  logic [11:0]        speed_gain_r;
  logic [14:0]        speed_limit_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_x_r      <= 16'sd256;
      goal_y_r      <= 16'sd256;
      speed_gain_r  <= 12'd256;
      speed_limit_r <= 15'd768;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        gtg_pkg::REG_GOAL_X:      goal_x_r      <= pwdata[15:0];
        gtg_pkg::REG_GOAL_Y:      goal_y_r      <= pwdata[15:0];
        gtg_pkg::REG_SPEED_GAIN:  speed_gain_r  <= pwdata[11:0];
        gtg_pkg::REG_SPEED_LIMIT: speed_limit_r <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Goal coordinates read back sign extended, the others zero extended.
  always_comb begin
    unique case (paddr[3:2])
      gtg_pkg::REG_GOAL_X:      prdata = 32'(goal_x_r);
      gtg_pkg::REG_GOAL_Y:      prdata = 32'(goal_y_r);
      gtg_pkg::REG_SPEED_GAIN:  prdata = {20'd0, speed_gain_r};
      gtg_pkg::REG_SPEED_LIMIT: prdata = {17'd0, speed_limit_r};
      default:                  prdata = '0;
    endcase
  end

  // The pipeline never holds back a pose.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------------
  // Stage A: goal vector with guard bits, prerotated into the right half plane.
  // ---------------------------------------------------------------------------
  logic signed [16:0]   dx;
  logic signed [16:0]   dy;
  logic signed [XW-1:0] dx_g;
  logic signed [XW-1:0] dy_g;
  gtg_pkg::gtg_vec_t    a_vec_nxt;
  gtg_pkg::gtg_vec_t    a_vec_r;
  logic signed [14:0]   a_hd_r;
  logic                 a_vld_r;

  assign dx   = 17'(goal_x_r) - 17'(in_pos_x);
  assign dy   = 17'(goal_y_r) - 17'(in_pos_y);
  assign dx_g = XW'(dx) <<< gtg_pkg::GUARD;
  assign dy_g = XW'(dy) <<< gtg_pkg::GUARD;

  // A vector in the left half plane is turned by a quarter turn first, so the
  // CORDIC only has to cover plus or minus ninety degrees.
  always_comb begin
    if (dx_g < 0 && dy_g >= 0) begin
      a_vec_nxt.x = dy_g;
      a_vec_nxt.y = -dx_g;
      a_vec_nxt.z = ZW'(gtg_pkg::HALF_PI_Q20);
    end else if (dx_g < 0) begin
      a_vec_nxt.x = -dy_g;
      a_vec_nxt.y = dx_g;
      a_vec_nxt.z = -ZW'(gtg_pkg::HALF_PI_Q20);
    end else begin
      a_vec_nxt.x = dx_g;
      a_vec_nxt.y = dy_g;
      a_vec_nxt.z = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    a_vec_r <= a_vec_nxt;
    a_hd_r  <= in_heading;
  end

  // ---------------------------------------------------------------------------
  // CORDIC stages; the heading rides along as a tag.
  // ---------------------------------------------------------------------------
  logic              c_vld;
  gtg_pkg::gtg_vec_t c_vec;
  logic [14:0]       c_tag;

  gtg_cordic #(
    .STAGES (CORDIC_STAGES),
    .TAG_W  (15)
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (a_vld_r),
    .in_vec    (a_vec_r),
    .in_tag    (a_hd_r),
    .out_valid (c_vld),
    .out_vec   (c_vec),
    .out_tag   (c_tag)
  );

  // ---------------------------------------------------------------------------
  // Stage M: distance from the CORDIC length, bearing and heading error.
  // ---------------------------------------------------------------------------
  logic [XW-2:0]        x_pos;
  logic [PW-1:0]        dist_prod;
  logic signed [ZW-1:0] z_round;
  logic signed [15:0]   bearing;
  logic signed [16:0]   err;
  logic [16:0]          err_abs;
  logic [DW-1:0]        m_dist_r;
  logic [14:0]          m_err_r;
  logic                 m_vld_r;

  assign x_pos     = c_vec.x[XW-1] ? '0 : c_vec.x[XW-2:0];
  // Scale by the inverse CORDIC gain in Q.16 and round half up to unsigned Q11.8.
  assign dist_prod = PW'(x_pos) * PW'(gtg_pkg::INV_GAIN_Q16)
                   + (PW'(1) << (15 + gtg_pkg::GUARD));
  assign z_round   = (c_vec.z + ZW'(128)) >>> 8;

  // The bearing is clamped to plus or minus pi before the heading is taken off.
  always_comb begin
    if (z_round > gtg_pkg::PI_Q12) begin
      bearing = 16'(gtg_pkg::PI_Q12);
    end else if (z_round < -gtg_pkg::PI_Q12) begin
      bearing = -16'(gtg_pkg::PI_Q12);
    end else begin
      bearing = z_round[15:0];
    end
  end

  assign err     = 17'(bearing) - 17'(signed'(c_tag));
  assign err_abs = err[16] ? 17'(-err) : 17'(err);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    m_dist_r <= dist_prod[PW-1 -: DW];
    m_err_r  <= err_abs[14:0];
  end

  // ---------------------------------------------------------------------------
  // Stage S: proportional speed and the two decisions.
  // ---------------------------------------------------------------------------
  logic [DW+11:0] spd_prod;
  logic [SW-1:0]  s_spd_r;
  logic [14:0]    s_err_r;
  logic           s_at_goal_r;
  logic           s_turn_r;
  logic           s_vld_r;

  assign spd_prod = (DW + 12)'(speed_gain_r) * (DW + 12)'(m_dist_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else begin
      s_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s_spd_r     <= spd_prod[DW+11:8];
    s_err_r     <= m_err_r;
    s_at_goal_r <= m_dist_r <= DW'(gtg_pkg::DIST_MIN_Q8);
    s_turn_r    <= m_err_r > 15'(gtg_pkg::ERR_MAX_Q12);
  end

  // ---------------------------------------------------------------------------
  // Stage O: pick the command. At the goal both are zero, a large heading
  // error turns in place, and otherwise the speed is capped at the limit.
  // ---------------------------------------------------------------------------
  logic [14:0] fwd_nxt;
  logic [14:0] turn_nxt;
  logic [14:0] fwd_r;
  logic [14:0] turn_r;
  logic        out_valid_r;

  always_comb begin
    fwd_nxt  = '0;
    turn_nxt = '0;
    if (!s_at_goal_r) begin
      if (s_turn_r) begin
        turn_nxt = s_err_r;
      end else if (s_spd_r > SW'(speed_limit_r)) begin
        fwd_nxt = speed_limit_r;
      end else begin
        fwd_nxt = s_spd_r[14:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    fwd_r  <= fwd_nxt;
    turn_r <= turn_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_forward_speed = fwd_r;
  assign out_turn_rate     = turn_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // Every accepted pose comes out after the fixed pipeline latency.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##(CORDIC_STAGES + 4) out_valid)
    else $error("accepted pose did not produce a result on time");

  // The block never drives forward and turns at the same time.
  a_exclusive : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_forward_speed == '0 || out_turn_rate == '0))
    else $error("forward speed and turn rate both nonzero");

  // The forward command respects the configured limit.
  a_limit : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_forward_speed <= speed_limit_r)
    else $error("forward speed above the speed limit");

  // A turn command is only issued for a heading error beyond the threshold.
  a_turn_min : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_turn_rate == '0 || out_turn_rate > 15'(gtg_pkg::ERR_MAX_Q12)))
    else $error("turn rate below the turning threshold");

endmodule
